/* rtl/robin_hood_hash_map_macros.svh */
// Assertion macros used by the hash map probe engine
`ifndef ROBIN_HOOD_HASH_MAP_MACROS_SVH
`define ROBIN_HOOD_HASH_MAP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define RHH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define RHH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rhh_pkg.sv */
// Types, constants and codes for the Robin Hood hash map
`default_nettype none
package rhh_pkg;

	localparam int SLOT_COUNT  = 256;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int HASH_WIDTH  = 32;
	localparam int SLOT_AW     = $clog2(SLOT_COUNT);
	localparam int DIST_W      = SLOT_AW;
	localparam int CNT_W       = SLOT_AW + 1;
	localparam int CFG_W       = 9;
	localparam int LIM_W       = (CFG_W > CNT_W) ? CFG_W : CNT_W;

	localparam logic [CFG_W-1:0] MAX_FILL_RESET = CFG_W'(230);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_FIND   = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FOUND    = 2'd1,
		ST_MISSING  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic                   command;
		logic [KEY_WIDTH-1:0]   key;
		logic [HASH_WIDTH-1:0]  key_hash;
		logic [VALUE_WIDTH-1:0] insert_value;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [VALUE_WIDTH-1:0] found_value;
	} rsp_t;

	// Result handoff from the probe engine to the output register
	typedef struct packed {
		logic valid;
		rsp_t data;
	} res_t;

	typedef struct packed {
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
		logic [DIST_W-1:0]      probe_dist;
	} slot_t;

endpackage
`default_nettype wire

/* rtl/rhh_ram.sv */
// Generic simple dual-port RAM with registered read
`default_nettype none
module rhh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/rhh_probe.sv */
// Probe engine: walks the slot store one slot per cycle for insert and find
`default_nettype none
module rhh_probe (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire rhh_pkg::req_t              req,
	input  wire logic [rhh_pkg::CFG_W-1:0]  max_fill,
	input  wire logic                       out_free,
	output rhh_pkg::res_t                   res
);
	`include "robin_hood_hash_map_macros.svh"

	typedef enum logic {S_IDLE, S_EVAL} state_t;

	state_t                              state_q;
	logic [rhh_pkg::SLOT_AW-1:0]         pos_q;
	logic [rhh_pkg::DIST_W-1:0]          dist_q;
	logic [rhh_pkg::KEY_WIDTH-1:0]       key_q;
	logic [rhh_pkg::VALUE_WIDTH-1:0]     val_q;
	logic                                cmd_q;
	logic                                reject_q;
	logic [rhh_pkg::SLOT_COUNT-1:0]      used_q;
	logic [rhh_pkg::CNT_W-1:0]           count_q;

	rhh_pkg::slot_t                      rd_slot;
	rhh_pkg::slot_t                      wr_slot;
	logic                                wr_en;
	logic [rhh_pkg::SLOT_AW-1:0]         rd_addr;
	logic [rhh_pkg::LIM_W-1:0]           limit;
	logic                                full;
	logic                                accept;
	logic                                occ;
	logic                                finish;
	logic                                advance;
	logic                                swap;
	rhh_pkg::status_t                    fin_status;
	logic [rhh_pkg::VALUE_WIDTH-1:0]     fin_value;

	rhh_ram #(
		.WIDTH($bits(rhh_pkg::slot_t)),
		.DEPTH(rhh_pkg::SLOT_COUNT)
	) u_slots (
		.clk  (clk),
		.we   (wr_en),
		.waddr(pos_q),
		.wdata(wr_slot),
		.raddr(rd_addr),
		.rdata(rd_slot)
	);

	assign limit = (rhh_pkg::LIM_W'(max_fill) > rhh_pkg::LIM_W'(rhh_pkg::SLOT_COUNT))
		? rhh_pkg::LIM_W'(rhh_pkg::SLOT_COUNT) : rhh_pkg::LIM_W'(max_fill);
	assign full      = (rhh_pkg::LIM_W'(count_q) + rhh_pkg::LIM_W'(1)) >= limit;
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign occ       = used_q[pos_q];

	always_comb begin
		finish     = 1'b0;
		advance    = 1'b0;
		swap       = 1'b0;
		fin_status = rhh_pkg::ST_MISSING;
		fin_value  = '0;
		if (state_q == S_EVAL) begin
			if (reject_q) begin
				finish     = 1'b1;
				fin_status = rhh_pkg::ST_FULL;
			end else if (cmd_q == rhh_pkg::CMD_FIND) begin
				if (!occ || dist_q > rd_slot.probe_dist) begin
					finish     = 1'b1;
					fin_status = rhh_pkg::ST_MISSING;
				end else if (rd_slot.key == key_q) begin
					finish     = 1'b1;
					fin_status = rhh_pkg::ST_FOUND;
					fin_value  = rd_slot.value;
				end else begin
					advance = 1'b1;
				end
			end else begin
				if (!occ) begin
					finish     = 1'b1;
					fin_status = rhh_pkg::ST_INSERTED;
				end else begin
					advance = 1'b1;
					swap    = rd_slot.probe_dist < dist_q;
				end
			end
		end
	end

	// Hold the write of a finishing insert until the result can be handed off
	assign wr_en        = swap || (finish && out_free && !reject_q
		&& cmd_q == rhh_pkg::CMD_INSERT);
	assign wr_slot.key        = key_q;
	assign wr_slot.value      = val_q;
	assign wr_slot.probe_dist = dist_q;

	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = req.key_hash[rhh_pkg::SLOT_AW-1:0];
		end else if (advance) begin
			rd_addr = pos_q + rhh_pkg::SLOT_AW'(1);
		end else begin
			rd_addr = pos_q;
		end
	end

	assign res.valid            = finish && out_free;
	assign res.data.status      = fin_status;
	assign res.data.found_value = fin_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			count_q  <= '0;
			reject_q <= 1'b0;
			cmd_q    <= rhh_pkg::CMD_INSERT;
			pos_q    <= '0;
			dist_q   <= '0;
			key_q    <= '0;
			val_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q  <= S_EVAL;
						cmd_q    <= req.command;
						reject_q <= (req.command == rhh_pkg::CMD_INSERT) && full;
						pos_q    <= req.key_hash[rhh_pkg::SLOT_AW-1:0];
						dist_q   <= '0;
						key_q    <= req.key;
						val_q    <= req.insert_value;
					end
				end
				S_EVAL: begin
					if (advance) begin
						pos_q  <= pos_q + rhh_pkg::SLOT_AW'(1);
						dist_q <= (swap ? rd_slot.probe_dist : dist_q) + rhh_pkg::DIST_W'(1);
						if (swap) begin
							key_q <= rd_slot.key;
							val_q <= rd_slot.value;
						end
					end else if (finish && out_free) begin
						state_q <= S_IDLE;
						if (wr_en) begin
							used_q[pos_q] <= 1'b1;
							count_q       <= count_q + rhh_pkg::CNT_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RHH_ASSERT_NOW(a_count_below_slots, 1'b1, count_q < rhh_pkg::CNT_W'(rhh_pkg::SLOT_COUNT), "entry count reached slot count")
	`RHH_ASSERT_NOW(a_no_dist_wrap, advance, dist_q != '1, "probe distance wrapped")
	`RHH_ASSERT_NOW(a_write_on_insert, wr_en, cmd_q == rhh_pkg::CMD_INSERT && !reject_q, "slot write outside an accepted insert")
	`RHH_ASSERT_NEXT(a_full_keeps_count, res.valid && res.data.status == rhh_pkg::ST_FULL, $stable(count_q) && $stable(used_q), "rejected insert changed the store")

endmodule
`default_nettype wire

/* rtl/robin_hood_hash_map.sv */
// Robin Hood hash map: 256 slots held in one registered-read RAM, probed
// linearly from the home slot (key_hash low bits), one slot per cycle. An item
// is accepted as its home slot read is launched; a rejected insert then ends
// without a probe. The probe rate is set by the slot RAM read latency: each
// cycle evaluates the slot read in the previous one and launches the read of
// the next. Slot occupancy is kept in flip-flops cleared at reset, so the map
// is usable right after reset with no clearing pass. Results sit in an output
// register, so the next request is taken while a result waits. The user must
// write max_fill only while the map is idle; the block does not enforce it.
// Inserts are rejected once entry count + 1 reaches max_fill, capped at 256.
`default_nettype none
module robin_hood_hash_map (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	output logic                           req_ready,
	input  wire rhh_pkg::req_t             req,
	output logic                           rsp_valid,
	input  wire logic                      rsp_ready,
	output rhh_pkg::rsp_t                  rsp,
	input  wire logic                      cfg_we,
	input  wire logic [rhh_pkg::CFG_W-1:0] cfg_wdata
);

	logic [rhh_pkg::CFG_W-1:0] max_fill_q;
	logic                      rsp_valid_q;
	rhh_pkg::rsp_t             rsp_q;
	rhh_pkg::res_t             res;
	logic                      out_free;

	assign out_free = !rsp_valid_q || rsp_ready;

	rhh_probe u_probe (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.max_fill (max_fill_q),
		.out_free (out_free),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fill_q  <= rhh_pkg::MAX_FILL_RESET;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_we) begin
				max_fill_q <= cfg_wdata;
			end
			// load a new result, or drop the old one once taken
			if (res.valid) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res.data;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

/* tb/sv/robin_hood_hash_map_checker.sv */
// Checker for the hash map: mirrors the slot store, predicts each result and compares
`timescale 1ns / 100ps
module robin_hood_hash_map_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	input  wire logic                      req_ready,
	input  wire rhh_pkg::req_t             req,
	input  wire logic                      rsp_valid,
	input  wire logic                      rsp_ready,
	input  wire rhh_pkg::rsp_t             rsp,
	input  wire logic                      cfg_we,
	input  wire logic [rhh_pkg::CFG_W-1:0] cfg_wdata,
	output int                             mismatch_count,
	output int                             awaited_count
);

	logic [rhh_pkg::KEY_WIDTH-1:0]   slot_key [rhh_pkg::SLOT_COUNT];
	logic [rhh_pkg::VALUE_WIDTH-1:0] slot_val [rhh_pkg::SLOT_COUNT];
	int unsigned                     slot_dist [rhh_pkg::SLOT_COUNT];
	bit                              slot_busy [rhh_pkg::SLOT_COUNT];
	int unsigned                     entry_total;
	logic [rhh_pkg::CFG_W-1:0]       fill_reg;
	rhh_pkg::rsp_t                   awaited_rsp [$];
	rhh_pkg::rsp_t                   head_rsp;

	function automatic rhh_pkg::rsp_t place_entry(input rhh_pkg::req_t item);
		rhh_pkg::rsp_t                   res;
		int unsigned                     cap;
		int unsigned                     pos;
		int unsigned                     carry_dist;
		int unsigned                     swap_dist;
		logic [rhh_pkg::KEY_WIDTH-1:0]   carry_key;
		logic [rhh_pkg::VALUE_WIDTH-1:0] carry_val;
		logic [rhh_pkg::KEY_WIDTH-1:0]   swap_key;
		logic [rhh_pkg::VALUE_WIDTH-1:0] swap_val;
		res.found_value = '0;
		cap = (fill_reg > rhh_pkg::SLOT_COUNT) ? rhh_pkg::SLOT_COUNT : fill_reg;
		if (entry_total + 1 >= cap) begin
			res.status = rhh_pkg::ST_FULL;
			return res;
		end
		entry_total++;
		res.status = rhh_pkg::ST_INSERTED;
		pos = item.key_hash[rhh_pkg::SLOT_AW-1:0];
		carry_dist = 0;
		carry_key = item.key;
		carry_val = item.insert_value;
		for (int step = 0; step < rhh_pkg::SLOT_COUNT; step++) begin
			if (!slot_busy[pos]) begin
				slot_busy[pos] = 1'b1;
				slot_key[pos] = carry_key;
				slot_val[pos] = carry_val;
				slot_dist[pos] = carry_dist;
				return res;
			end
			// take the slot from a resident that sits closer to its home
			if (slot_dist[pos] < carry_dist) begin
				swap_key = slot_key[pos];
				swap_val = slot_val[pos];
				swap_dist = slot_dist[pos];
				slot_key[pos] = carry_key;
				slot_val[pos] = carry_val;
				slot_dist[pos] = carry_dist;
				carry_key = swap_key;
				carry_val = swap_val;
				carry_dist = swap_dist;
			end
			carry_dist++;
			pos = (pos + 1) % rhh_pkg::SLOT_COUNT;
		end
		return res;
	endfunction

	function automatic rhh_pkg::rsp_t look_up(input rhh_pkg::req_t item);
		rhh_pkg::rsp_t res;
		int unsigned   pos;
		res.status = rhh_pkg::ST_MISSING;
		res.found_value = '0;
		pos = item.key_hash[rhh_pkg::SLOT_AW-1:0];
		for (int unsigned walked = 0; walked < rhh_pkg::SLOT_COUNT; walked++) begin
			if (!slot_busy[pos] || walked > slot_dist[pos])
				return res;
			if (slot_key[pos] == item.key) begin
				res.status = rhh_pkg::ST_FOUND;
				res.found_value = slot_val[pos];
				return res;
			end
			pos = (pos + 1) % rhh_pkg::SLOT_COUNT;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (slot_busy[i])
				slot_busy[i] = 1'b0;
			entry_total = 0;
			fill_reg = rhh_pkg::MAX_FILL_RESET;
			awaited_rsp.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_we)
				fill_reg = cfg_wdata;
			// compare before predicting, so a stray result never meets this cycle's request
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result transaction: status %0d value %h",
							rsp.status, rsp.found_value);
				end else begin
					head_rsp = awaited_rsp.pop_front();
					if (rsp.status !== head_rsp.status ||
							rsp.found_value !== head_rsp.found_value) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"result mismatch: expected status %0d value %h, ",
								"got status %0d value %h"},
								head_rsp.status, head_rsp.found_value,
								rsp.status, rsp.found_value);
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req.command == rhh_pkg::CMD_INSERT)
					awaited_rsp.push_back(place_entry(req));
				else
					awaited_rsp.push_back(look_up(req));
			end
		end
		awaited_count = awaited_rsp.size();
	end

endmodule

/* tb/sv/robin_hood_hash_map_tb.sv */
// Testbench top for the hash map: drives requests, config and backpressure, reports the verdict
`timescale 1ns / 100ps
module robin_hood_hash_map_tb;

	logic                      clk;
	logic                      arst_n;
	logic                      req_valid;
	logic                      req_ready;
	rhh_pkg::req_t             req;
	logic                      rsp_valid;
	logic                      rsp_ready;
	rhh_pkg::rsp_t             rsp;
	logic                      cfg_we;
	logic [rhh_pkg::CFG_W-1:0] cfg_wdata;
	int                        mismatch_count;
	int                        awaited_count;
	bit                        calm;
	logic [31:0]               stored_key [$];
	logic [31:0]               stored_hash [$];

	robin_hood_hash_map DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	robin_hood_hash_map_checker map_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp            (rsp),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.awaited_count  (awaited_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	// result side backpressure
	initial begin
		rsp_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
		end
	end

	// starts and ends at a falling edge; valid stays high after the transaction
	task automatic send_item(input logic cmd, input logic [31:0] key_in,
			input logic [31:0] hash_in, input logic [31:0] value_in);
		int gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 7);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= {cmd, key_in, hash_in, value_in};
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		if (cmd == rhh_pkg::CMD_INSERT) begin
			stored_key.push_back(key_in);
			stored_hash.push_back(hash_in);
		end
	endtask

	// hold requests until every outstanding result is back
	task automatic settle();
		req_valid <= 1'b0;
		do @(negedge clk); while (awaited_count != 0);
	endtask

	task automatic write_fill(input logic [rhh_pkg::CFG_W-1:0] limit);
		settle();
		cfg_wdata <= limit;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_mix(input int count, input int insert_pct);
		int          pick;
		int          sel;
		logic [31:0] key_pick;
		logic [31:0] hash_pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			key_pick = $urandom;
			hash_pick = $urandom;
			// crowd homes near the top slot so probes wrap
			if ($urandom_range(0, 2) == 0)
				hash_pick[7:0] = 8'(248 + $urandom_range(0, 15));
			if (pick < insert_pct) begin
				if (stored_key.size() != 0 && $urandom_range(0, 9) == 0) begin
					sel = $urandom_range(0, stored_key.size() - 1);
					key_pick = stored_key[sel];
					hash_pick = stored_hash[sel];
				end
				send_item(rhh_pkg::CMD_INSERT, key_pick, hash_pick, $urandom);
			end else if (pick < insert_pct + (100 - insert_pct) * 3 / 4 &&
					stored_key.size() != 0) begin
				sel = $urandom_range(0, stored_key.size() - 1);
				send_item(rhh_pkg::CMD_FIND, stored_key[sel], stored_hash[sel], $urandom);
			end else begin
				send_item(rhh_pkg::CMD_FIND, key_pick, hash_pick, $urandom);
			end
			if ($urandom_range(0, 59) == 0)
				settle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(rhh_pkg::CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_item(rhh_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// home at the top slot wraps to slot zero and displaces the resident
		send_item(rhh_pkg::CMD_INSERT, 32'h0000_0001, 32'h0000_00FF, 32'h1111_1111);
		send_item(rhh_pkg::CMD_FIND, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(rhh_pkg::CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(rhh_pkg::CMD_FIND, 32'h0000_0001, 32'h0000_00FF, 32'h0000_0000);
		// duplicate key: the first copy on the path wins
		send_item(rhh_pkg::CMD_INSERT, 32'h0000_0055, 32'h8000_0010, 32'hAAAA_0001);
		send_item(rhh_pkg::CMD_INSERT, 32'h0000_0055, 32'h8000_0010, 32'hAAAA_0002);
		send_item(rhh_pkg::CMD_FIND, 32'h0000_0055, 32'h8000_0010, 32'h0000_0000);
		// build a cluster where a poorer entry steals a slot
		send_item(rhh_pkg::CMD_INSERT, 32'hC0DE_0042, 32'h0000_0042, 32'h4242_4242);
		send_item(rhh_pkg::CMD_INSERT, 32'hC0DE_0040, 32'h1234_5640, 32'h4040_0000);
		send_item(rhh_pkg::CMD_INSERT, 32'hC0DE_0041, 32'h7FFF_FF40, 32'h4040_0001);
		send_item(rhh_pkg::CMD_INSERT, 32'hC0DE_0043, 32'hFFFF_FF40, 32'h4040_0002);
		send_item(rhh_pkg::CMD_FIND, 32'hC0DE_0042, 32'h0000_0042, 32'h0000_0000);
		send_item(rhh_pkg::CMD_FIND, 32'hC0DE_0043, 32'hFFFF_FF40, 32'h0000_0000);
		// missing keys: stop at a closer resident, at an empty home, at a wrong home
		send_item(rhh_pkg::CMD_FIND, 32'hDEAD_0040, 32'h0000_0040, 32'h0000_0000);
		send_item(rhh_pkg::CMD_FIND, 32'hDEAD_0044, 32'h0000_0044, 32'h0000_0000);
		send_item(rhh_pkg::CMD_FIND, 32'hC0DE_0040, 32'h0000_0041, 32'h0000_0000);

		// limits of zero and one reject every insert
		write_fill('0);
		send_item(rhh_pkg::CMD_INSERT, 32'h0000_0077, 32'h0000_0077, 32'h7777_7777);
		send_item(rhh_pkg::CMD_FIND, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		write_fill(1);
		send_item(rhh_pkg::CMD_INSERT, 32'h0000_0078, 32'h0000_0078, 32'h7878_7878);
		// cross the fill limit
		write_fill(14);
		repeat (6) send_item(rhh_pkg::CMD_INSERT, $urandom, $urandom, $urandom);

		write_fill(96);
		random_mix(170, 45);
		// all ones saturates to the slot count
		write_fill('1);
		random_mix(170, 60);
		write_fill(256);
		random_mix(110, 40);
		calm = 1'b1;
		random_mix(60, 40);

		settle();
		repeat (300) @(negedge clk);
		if (mismatch_count == 0 && awaited_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
